// ===== design/gids_pkg.sv =====
// Shared types and fixed field widths for the greedy influence dominating set block.
// No dependencies; compiled first.
package gids_pkg;

  localparam int VTX_W = 7;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [VTX_W-1:0] first_end;
    logic [VTX_W-1:0] second_end;
    logic             no_edge;
    logic             last_edge;
  } gids_edge_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             empty_set;
    logic             last;
  } gids_result_t;

endpackage

// ===== design/gids_edge_if.sv =====
// Edge input channel: valid/ready handshake carrying one edge item.
// Depends on gids_pkg.
interface gids_edge_if;
  import gids_pkg::*;
  logic       valid;
  logic       ready;
  gids_edge_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/gids_result_if.sv =====
// Result output channel: valid/ready handshake carrying one chosen vertex.
// Depends on gids_pkg.
interface gids_result_if;
  import gids_pkg::*;
  logic         valid;
  logic         ready;
  gids_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/gids_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No package dependency.
module gids_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/greedy_influence_dominating_set.sv =====
// Top level of the greedy positive-influence dominating set block.
// Depends on gids_pkg, gids_edge_if, gids_result_if and gids_ram.
//
// Usage:
//   edge_i transfers one edge item (1-based endpoints, no_edge, last_edge).
//   Each edge is a read-modify-write of the multiplicity matrix RAM in
//   steps (read, write of one entry, write of its mirror); a self-loop
//   or an ignored edge skips the mirror write.
//   cfg_we_i/cfg_wdata_i write vertex_count; write only while idle.
//   On the item with last_edge the search runs from the matrix RAM: degrees
//   are summed row by row, then each vertex is tested with one pass over its
//   column and, if dropped, its column is taken out of the counts in another.
//   The emission scan then steps through the vertices, so chosen vertices
//   leave on res_o at most one per cycle in ascending order, the final one
//   flagged last; an empty set gives one empty marker.
//   A stalled receiver holds the result register and pauses the emission.
//   After reset and after each graph's last result is loaded, a clearing
//   pass writes zero to every one of the 4**ceil(log2(MAX_VERTICES)) matrix
//   entries (4096 at the default); edge_i is not ready during it.
//   Reset also sets vertex_count to 64.
module greedy_influence_dominating_set #(
  parameter int MAX_VERTICES     = 64,
  parameter int MULTIPLICITY_MAX = 255
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gids_pkg::CFG_W-1:0]  cfg_wdata_i,
  gids_edge_if.sink                   edge_i,
  gids_result_if.source               res_o
);
  import gids_pkg::*;

  localparam int IW     = $clog2(MAX_VERTICES);
  localparam int AW     = 2 * IW;
  localparam int MDEPTH = 1 << AW;
  localparam int MW     = $clog2(MULTIPLICITY_MAX + 1);
  localparam int DW     = $clog2(MAX_VERTICES * MULTIPLICITY_MAX + 1);
  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int CW     = (NW > VTX_W) ? NW : VTX_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EDGE_WR1, ST_EDGE_WR2, ST_DEG, ST_TEST, ST_SUB, ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] vertex_count_q;
  logic [AW-1:0]    clr_q;
  logic [IW-1:0]    x_q, y_q, i_q, j_q, c_q, pi_q;
  logic             upd_q, self_q, last_q;
  logic [NW-1:0]    n_q, n_cur;
  logic [MW-1:0]    new_q;
  logic             iss_q, pv_q, plast_q, pfirst_q, pend_q, ok_q;
  logic [DW-1:0]    acc_q;
  logic [MAX_VERTICES-1:0] chosen_q;
  logic             out_vld_q;
  gids_result_t     out_q;

  // Memory ports
  logic          mat_we;
  logic [AW-1:0] mat_waddr, mat_raddr;
  logic [MW-1:0] mat_wdata, mat_rdata;
  logic          vtx_we;
  logic [IW-1:0] vtx_waddr;
  logic [2*DW-1:0] vtx_wdata, vtx_rdata;

  gids_ram #(.Width(MW), .Depth(MDEPTH)) u_mat_ram (
    .clk_i, .we_i(mat_we), .waddr_i(mat_waddr), .wdata_i(mat_wdata),
    .raddr_i(mat_raddr), .rdata_o(mat_rdata)
  );

  gids_ram #(.Width(2 * DW), .Depth(MAX_VERTICES)) u_vtx_ram (
    .clk_i, .we_i(vtx_we), .waddr_i(vtx_waddr), .wdata_i(vtx_wdata),
    .raddr_i(i_q), .rdata_o(vtx_rdata)
  );

  // Clamp vertex count into 1..MAX_VERTICES
  always_comb begin
    if (vertex_count_q == '0) begin
      n_cur = NW'(1);
    end else if (CW'(vertex_count_q) > CW'(MAX_VERTICES)) begin
      n_cur = NW'(MAX_VERTICES);
    end else begin
      n_cur = NW'(vertex_count_q);
    end
  end

  // Decode incoming edge
  logic [CW-1:0] a_ext, b_ext;
  logic [IW-1:0] x_in, y_in;
  logic          edge_ok;
  logic          in_xfer;
  assign a_ext   = CW'(edge_i.data.first_end);
  assign b_ext   = CW'(edge_i.data.second_end);
  assign x_in    = IW'(a_ext - CW'(1));
  assign y_in    = IW'(b_ext - CW'(1));
  assign edge_ok = !edge_i.data.no_edge && (a_ext != '0) && (b_ext != '0) &&
                   (a_ext <= CW'(n_cur)) && (b_ext <= CW'(n_cur));
  assign edge_i.ready = (state_q == ST_IDLE);
  assign in_xfer      = edge_i.valid && edge_i.ready;

  // Saturating increment of the read entry
  logic [MW+1:0] inc_sum;
  logic [MW-1:0] sat_val;
  assign inc_sum = {2'b00, mat_rdata} + (self_q ? (MW+2)'(2) : (MW+2)'(1));
  assign sat_val = (inc_sum > (MW+2)'(MULTIPLICITY_MAX)) ? MW'(MULTIPLICITY_MAX)
                                                         : inc_sum[MW-1:0];

  // Sweep helpers
  logic [IW-1:0] nm1;
  logic          i_end, j_end;
  assign nm1   = IW'(n_q - NW'(1));
  assign i_end = (i_q == nm1);
  assign j_end = (j_q == nm1);

  // Degree accumulation and per-vertex checks
  logic [DW-1:0] acc_sum, need_new, v_cnt, v_need;
  logic [DW:0]   need_wide;
  logic          test_fail;
  assign acc_sum   = (pfirst_q ? '0 : acc_q) + DW'(mat_rdata);
  assign need_wide = ({1'b0, acc_sum} + (DW+1)'(1)) >> 1;
  assign need_new  = need_wide[DW-1:0];
  assign v_cnt     = vtx_rdata[DW-1:0];
  assign v_need    = vtx_rdata[2*DW-1:DW];
  assign test_fail = {1'b0, v_cnt} < ({1'b0, v_need} + (DW+1)'(mat_rdata));

  // Memory controls
  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = {x_q, y_q};
    mat_wdata = sat_val;
    mat_raddr = {i_q, (state_q == ST_DEG) ? j_q : c_q};
    vtx_we    = 1'b0;
    vtx_waddr = pi_q;
    vtx_wdata = {need_new, acc_sum};
    case (state_q)
      ST_CLEAR: begin
        mat_we    = 1'b1;
        mat_waddr = clr_q;
        mat_wdata = '0;
      end
      ST_IDLE: begin
        mat_raddr = {x_in, y_in};
      end
      ST_EDGE_WR1: begin
        mat_we = upd_q;
      end
      ST_EDGE_WR2: begin
        mat_we    = 1'b1;
        mat_waddr = {y_q, x_q};
        mat_wdata = new_q;
      end
      ST_DEG: begin
        vtx_we = pv_q && pend_q;
      end
      ST_SUB: begin
        vtx_we    = pv_q;
        vtx_wdata = {v_need, v_cnt - DW'(mat_rdata)};
      end
      default: ;
    endcase
  end

  // Emission look-ahead: any chosen vertex above c within range
  logic any_above;
  always_comb begin
    any_above = 1'b0;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if (chosen_q[k] && (k > int'(c_q)) && (k < int'(n_q))) begin
        any_above = 1'b1;
      end
    end
  end

  logic slot_free;
  assign slot_free = !out_vld_q || res_o.ready;

  // Control sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      vertex_count_q <= VERTEX_COUNT_RST;
      clr_q          <= '0;
      iss_q          <= 1'b0;
      pv_q           <= 1'b0;
      chosen_q       <= '1;
      out_vld_q      <= 1'b0;
      i_q            <= '0;
      j_q            <= '0;
      c_q            <= '0;
      n_q            <= NW'(1);
    end else begin
      if (cfg_we_i) begin
        vertex_count_q <= cfg_wdata_i;
      end
      if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      // Delay line tracking the read in flight
      pv_q     <= iss_q;
      pi_q     <= i_q;
      pfirst_q <= (j_q == '0);
      pend_q   <= j_end;
      plast_q  <= i_end && ((state_q != ST_DEG) || j_end);

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            x_q     <= x_in;
            y_q     <= y_in;
            self_q  <= (x_in == y_in);
            upd_q   <= edge_ok;
            last_q  <= edge_i.data.last_edge;
            n_q     <= n_cur;
            state_q <= ST_EDGE_WR1;
          end
        end
        ST_EDGE_WR1: begin
          new_q <= sat_val;
          if (upd_q && !self_q) begin
            state_q <= ST_EDGE_WR2;
          end else if (last_q) begin
            state_q <= ST_DEG;
            i_q     <= '0;
            j_q     <= '0;
            iss_q   <= 1'b1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EDGE_WR2: begin
          if (last_q) begin
            state_q <= ST_DEG;
            i_q     <= '0;
            j_q     <= '0;
            iss_q   <= 1'b1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DEG: begin
          // Issue row-major reads
          if (iss_q) begin
            if (j_end) begin
              j_q <= '0;
              if (i_end) begin
                iss_q <= 1'b0;
              end else begin
                i_q <= i_q + IW'(1);
              end
            end else begin
              j_q <= j_q + IW'(1);
            end
          end
          // Accumulate returned entries
          if (pv_q) begin
            acc_q <= acc_sum;
            if (plast_q) begin
              state_q <= ST_TEST;
              c_q     <= '0;
              i_q     <= '0;
              iss_q   <= 1'b1;
              ok_q    <= 1'b1;
            end
          end
        end
        ST_TEST, ST_SUB: begin
          if (iss_q) begin
            if (i_end) begin
              iss_q <= 1'b0;
            end else begin
              i_q <= i_q + IW'(1);
            end
          end
          if (pv_q && (state_q == ST_TEST) && test_fail) begin
            ok_q <= 1'b0;
          end
          if (pv_q && plast_q) begin
            i_q   <= '0;
            iss_q <= 1'b1;
            ok_q  <= 1'b1;
            if ((state_q == ST_TEST) && ok_q && !test_fail) begin
              // Drop vertex c and take its column out of the counts
              chosen_q[c_q] <= 1'b0;
              state_q       <= ST_SUB;
            end else if (c_q == nm1) begin
              state_q <= ST_EMIT;
              iss_q   <= 1'b0;
              c_q     <= '0;
            end else begin
              state_q <= ST_TEST;
              c_q     <= c_q + IW'(1);
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (chosen_q[c_q]) begin
              out_vld_q       <= 1'b1;
              out_q.vertex    <= VTX_W'(c_q) + VTX_W'(1);
              out_q.empty_set <= 1'b0;
              out_q.last      <= !any_above;
            end else if (c_q == nm1) begin
              out_vld_q       <= 1'b1;
              out_q.vertex    <= '0;
              out_q.empty_set <= 1'b1;
              out_q.last      <= 1'b1;
            end
            if ((chosen_q[c_q] && !any_above) || (c_q == nm1)) begin
              state_q  <= ST_CLEAR;
              clr_q    <= '0;
              chosen_q <= '1;
            end else begin
              c_q <= c_q + IW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

endmodule

// ===== design/gids_checker.sv =====
// Port-level checks for greedy_influence_dominating_set, attached by bind.
// Depends on gids_pkg and the top level's interface ports.
module gids_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [gids_pkg::VTX_W-1:0] res_vertex_i,
  input logic                       res_empty_i,
  input logic                       res_last_i
);
  import gids_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_vertex_i) &&
      $stable(res_empty_i) && $stable(res_last_i))
    else $error("stalled result changed");

  // Empty marker is vertex zero and closes the graph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_empty_i |-> res_last_i && (res_vertex_i == '0))
    else $error("malformed empty marker");

  // A chosen vertex is never numbered zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_empty_i |-> res_vertex_i != '0)
    else $error("chosen vertex zero");

  // The search blocks new edges right after the final edge transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("edge accepted during search");

endmodule

bind greedy_influence_dominating_set gids_checker u_gids_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (edge_i.valid),
  .in_ready_i   (edge_i.ready),
  .in_last_i    (edge_i.data.last_edge),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_vertex_i (res_o.data.vertex),
  .res_empty_i  (res_o.data.empty_set),
  .res_last_i   (res_o.data.last)
);

// ===== test/tb_greedy_influence_dominating_set.sv =====
// Testbench for greedy_influence_dominating_set: loads random and directed graphs,
// predicts the chosen vertices internally and checks each result transfer.
// Depends on gids_pkg, gids_edge_if, gids_result_if and the block's RTL.
module tb_greedy_influence_dominating_set;
  timeunit 1ns;
  timeprecision 1ps;
  import gids_pkg::*;

  localparam int NV      = 64;
  localparam int MULT_MX = 255;
  localparam int SETTLE  = 4400;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  gids_edge_if   edge_ch ();
  gids_result_if res_ch ();

  greedy_influence_dominating_set u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_ch),
    .res_o       (res_ch)
  );

  // Mirror of the block state
  int unsigned  mult [NV][NV];
  logic [6:0]   vcount_reg;
  gids_result_t chosen_q[$];
  int           errors;
  bit           rx_hold;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Work out the results of one accepted edge item
  task automatic predict_item(gids_edge_t it);
    int unsigned n, x, y, deg, need[NV], cnt[NV], k;
    bit          ok, keep[NV];
    gids_result_t r;
    n = vcount_reg;
    if (n < 1) n = 1;
    if (n > NV) n = NV;
    if (!it.no_edge && it.first_end >= 1 && it.second_end >= 1 &&
        it.first_end <= n && it.second_end <= n) begin
      x = it.first_end - 1;
      y = it.second_end - 1;
      if (x == y) begin
        mult[x][x] = (mult[x][x] + 2 > MULT_MX) ? MULT_MX : mult[x][x] + 2;
      end else begin
        mult[x][y] = (mult[x][y] + 1 > MULT_MX) ? MULT_MX : mult[x][y] + 1;
        mult[y][x] = (mult[y][x] + 1 > MULT_MX) ? MULT_MX : mult[y][x] + 1;
      end
    end
    if (!it.last_edge) return;
    for (int i = 0; i < n; i++) begin
      deg = 0;
      for (int j = 0; j < n; j++) deg += mult[i][j];
      need[i] = (deg + 1) / 2;
      cnt[i]  = deg;
      keep[i] = 1'b1;
    end
    // Drop each vertex in turn while every vertex keeps enough chosen neighbours
    for (int c = 0; c < n; c++) begin
      ok = 1'b1;
      for (int i = 0; i < n; i++)
        if (cnt[i] - mult[i][c] < need[i]) ok = 1'b0;
      if (ok) begin
        keep[c] = 1'b0;
        for (int i = 0; i < n; i++) cnt[i] -= mult[i][c];
      end
    end
    k = 0;
    for (int c = 0; c < n; c++) begin
      if (keep[c]) begin
        r.vertex    = 7'(c + 1);
        r.empty_set = 1'b0;
        r.last      = 1'b0;
        chosen_q = {chosen_q, r};
        k++;
      end
    end
    if (k == 0) begin
      r.vertex    = '0;
      r.empty_set = 1'b1;
      r.last      = 1'b1;
      chosen_q = {chosen_q, r};
    end else begin
      chosen_q[$].last = 1'b1;
    end
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++) mult[i][j] = 0;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one edge item; valid stays high after the transfer
  task automatic send_item(logic [6:0] a, logic [6:0] b, bit ne, bit le, bit gaps);
    int g;
    gids_edge_t it;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      edge_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    it.first_end  = a;
    it.second_end = b;
    it.no_edge    = ne;
    it.last_edge  = le;
    edge_ch.data  <= it;
    edge_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!edge_ch.ready);
    predict_item(it);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain_results();
    edge_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (chosen_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_vcount(logic [6:0] v);
    drain_results();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    vcount_reg = v;
  endtask

  // One graph: mostly in-range edges, some noise, closing item maybe with an edge
  task automatic send_graph(int n, int edges);
    logic [6:0] a, b;
    int p;
    for (int e = 0; e < edges; e++) begin
      p = $urandom_range(0, 99);
      if (p < 80) begin
        a = 7'($urandom_range(1, n));
        b = 7'($urandom_range(1, n));
      end else begin
        a = 7'($urandom_range(0, 127));
        b = 7'($urandom_range(0, 127));
      end
      send_item(a, b, ($urandom_range(0, 9) == 0), 1'b0, 1'b1);
    end
    send_item(7'($urandom_range(1, n)), 7'($urandom_range(0, 127)),
              1'($urandom_range(0, 1)), 1'b1, 1'b1);
  endtask

  // Receiver: random stalls unless a long hold-off is in force
  int rx_gap;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_gap <= 0;
    end else if (rx_hold) begin
      res_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap       <= rx_gap - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      rx_gap       <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    gids_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (chosen_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, res_ch.data);
        errors++;
      end else begin
        want = chosen_q.pop_front();
        if (res_ch.data.vertex !== want.vertex ||
            res_ch.data.empty_set !== want.empty_set ||
            res_ch.data.last !== want.last) begin
          $display("%0t: result mismatch, expected %p, actual %p",
                   $realtime, want, res_ch.data);
          errors++;
        end
      end
    end
  end

  // Long receiver hold-off counted here
  task automatic hold_receiver(int cycles);
    fork
      begin
        rx_hold = 1'b1;
        repeat (cycles) @(negedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
  endtask

  task automatic test_directed();
    write_vcount(7'd1);
    send_item(7'd0, 7'd0, 1'b1, 1'b1, 1'b0);
    write_vcount(7'd0);
    send_item(7'd1, 7'd1, 1'b0, 1'b1, 1'b0);
    write_vcount(7'd4);
    send_item(7'd1, 7'd2, 1'b0, 1'b0, 1'b0);
    send_item(7'd2, 7'd3, 1'b0, 1'b0, 1'b0);
    send_item(7'd5, 7'd1, 1'b0, 1'b0, 1'b0);
    send_item(7'd0, 7'd3, 1'b0, 1'b0, 1'b0);
    send_item(7'd3, 7'd3, 1'b1, 1'b0, 1'b0);
    send_item(7'd4, 7'd3, 1'b0, 1'b1, 1'b0);
    write_vcount(7'd100);
    send_item(7'd64, 7'd1, 1'b0, 1'b0, 1'b0);
    send_item(7'd65, 7'd2, 1'b0, 1'b0, 1'b0);
    send_item(7'd127, 7'd127, 1'b0, 1'b0, 1'b0);
    send_item(7'd64, 7'd64, 1'b0, 1'b0, 1'b0);
    send_item(7'd32, 7'd33, 1'b0, 1'b1, 1'b0);
    write_vcount(7'd64);
    send_item(7'd10, 7'd20, 1'b0, 1'b0, 1'b0);
    // Let the edge update finish, then shrink n mid-graph:
    // the search ignores the rows above the new n
    edge_ch.valid <= 1'b0;
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 7'd8;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    vcount_reg = 7'd8;
    send_item(7'd2, 7'd8, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_saturation();
    write_vcount(7'd2);
    for (int i = 0; i < 130; i++) send_item(7'd1, 7'd1, 1'b0, 1'b0, (i % 8) == 0);
    send_item(7'd1, 7'd2, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    write_vcount(7'd6);
    hold_receiver(3000);
    send_graph(6, 5);
    send_graph(6, 4);
    send_graph(6, 4);
  endtask

  task automatic test_random();
    int n;
    for (int g = 0; g < 20; g++) begin
      n = (g % 7 == 6) ? NV : $urandom_range(1, 8);
      if (g % 3 == 0) write_vcount(7'(n));
      else n = (vcount_reg < 1) ? 1 : ((vcount_reg > NV) ? NV : vcount_reg);
      send_graph(n, $urandom_range(2, 12));
      if (g % 5 == 4) drain_results();
    end
  endtask

  initial begin
    errors        = 0;
    rx_hold       = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    edge_ch.valid = 1'b0;
    edge_ch.data  = '0;
    res_ch.ready  = 1'b0;
    vcount_reg    = VERTEX_COUNT_RST;
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++) mult[i][j] = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_saturation();
    test_backpressure();
    test_random();
    drain_results();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0 && chosen_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
